/* rtl/core/assert_macros.svh */
// assertion macros shared by the checker files
// depends on a clock named i_clk and an active-low reset named i_rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define SEM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// checked at every edge, reset included
`define SEM_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/core/sem_pkg.sv */
// shared types and constants of the sobel edge magnitude block
// no dependencies
package sem_pkg;

    localparam int PIX_W     = 8;
    localparam int SUM_W     = 30;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 12'd2048;
    localparam logic [PIX_W-1:0]  EDGE_MAX       = 8'd255;
    localparam logic [SUM_W-1:0]  SUM_MAX        = 30'h3FFF_FFFF;

    // queue between front and back, and result queue
    localparam int MQ_DEPTH = 4;
    localparam int MQ_CNT_W = $clog2(MQ_DEPTH + 1);
    localparam int MQ_OCC_W = MQ_CNT_W + 1;
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);
    localparam int OQ_OCC_W = OQ_CNT_W + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } t_cfg_idx;

    // [row*3 + col], row 0 oldest, col 2 newest
    typedef logic [8:0][PIX_W-1:0] t_window;

    typedef struct packed {
        logic    clr;   // sum restarts before this item
        logic    last;
        t_window win;
    } t_win_item;

    typedef struct packed {
        logic [PIX_W-1:0] edge_value;
        logic             last_of_frame;
        logic [SUM_W-1:0] frame_sum;
    } t_result;

endpackage

/* rtl/core/sem_fifo.sv */
// small register queue with occupancy count
// depends on nothing but its parameters
module sem_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr;
    logic [PW-1:0]    r_rd;
    logic [CW-1:0]    r_count;
    logic             do_pop;

    assign do_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({i_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

endmodule

/* rtl/core/sem_front.sv */
// front part: raster counters, line buffers, 3x3 window and interior classification
// depends on sem_pkg
module sem_front
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [PIX_W-1:0]    i_pixel,
    input  logic [CFG_W-1:0]    i_image_width,
    input  logic [CFG_W-1:0]    i_image_height,
    input  logic [MQ_CNT_W-1:0] i_q_count,
    output logic                o_full,
    output logic                o_item_push,
    output t_win_item           o_item
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int HW  = $clog2(MAX_HEIGHT + 1);
    localparam int EWX = (WW > CFG_W) ? WW : CFG_W;
    localparam int EHX = (HW > CFG_W) ? HW : CFG_W;

    logic [PIX_W-1:0] r_buf_upper  [MAX_WIDTH];
    logic [PIX_W-1:0] r_buf_middle [MAX_WIDTH];

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             r_clr_pend;

    logic             r_f1_valid;
    logic [PIX_W-1:0] r_f1_pix;
    logic [CW-1:0]    r_f1_col;
    logic             r_f1_emit;
    logic             r_f1_last;
    logic             r_f1_clr;
    logic [PIX_W-1:0] r_top_rd;
    logic [PIX_W-1:0] r_mid_rd;

    t_window          r_win;
    t_window          n_win;

    logic [EWX-1:0]   w_ext;
    logic [EHX-1:0]   h_ext;
    logic [WW-1:0]    w;
    logic [HW-1:0]    h;
    logic [WW-1:0]    col_ext;
    logic [WW-1:0]    col_inc;
    logic [HW-1:0]    row_ext;
    logic [HW-1:0]    row_inc;
    logic             accept;
    logic             emit;
    logic             last;
    logic             row_end;
    logic             frame_end;
    logic [MQ_OCC_W-1:0] occ;

    // sizes clamped to 3..max
    assign w_ext = EWX'(i_image_width);
    assign h_ext = EHX'(i_image_height);
    assign w = (w_ext < EWX'(3))          ? WW'(3) :
               (w_ext > EWX'(MAX_WIDTH))  ? WW'(MAX_WIDTH) : WW'(w_ext);
    assign h = (h_ext < EHX'(3))          ? HW'(3) :
               (h_ext > EHX'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(h_ext);

    assign col_ext = WW'(r_col);
    assign col_inc = col_ext + WW'(1);
    assign row_ext = HW'(r_row);
    assign row_inc = row_ext + HW'(1);

    assign emit = (row_ext >= HW'(2)) && (col_ext >= WW'(2)) && (row_ext < h) && (col_ext < w);
    assign last = (row_ext == h - HW'(1)) && (col_ext == w - WW'(1));
    assign row_end   = (col_inc >= w);
    assign frame_end = row_end && (row_inc >= h);

    // one slot in the queue is kept for the item in the window stage
    assign occ    = MQ_OCC_W'(i_q_count) + MQ_OCC_W'(r_f1_valid);
    assign o_full = (occ >= MQ_OCC_W'(MQ_DEPTH));
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_clr_pend <= 1'b0;
            r_f1_valid <= 1'b0;
        end else begin
            r_f1_valid <= accept;
            if (accept) begin
                if (row_end) begin
                    r_col <= '0;
                    r_row <= frame_end ? '0 : RW'(row_inc);
                end else begin
                    r_col <= CW'(col_inc);
                end
                if (frame_end) begin
                    r_clr_pend <= 1'b1;
                end else if (emit) begin
                    r_clr_pend <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_f1_pix  <= i_pixel;
            r_f1_col  <= r_col;
            r_f1_emit <= emit;
            r_f1_last <= last;
            r_f1_clr  <= r_clr_pend;
        end
    end

    // line buffers: read at accept, written back in the following cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_top_rd <= r_buf_upper[r_col];
            r_mid_rd <= r_buf_middle[r_col];
        end
        if (r_f1_valid) begin
            r_buf_upper[r_f1_col]  <= r_mid_rd;
            r_buf_middle[r_f1_col] <= r_f1_pix;
        end
    end

    always_comb begin
        n_win    = r_win;
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = r_top_rd;
        n_win[3] = r_win[4];
        n_win[4] = r_win[5];
        n_win[5] = r_mid_rd;
        n_win[6] = r_win[7];
        n_win[7] = r_win[8];
        n_win[8] = r_f1_pix;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win <= '0;
        end else if (r_f1_valid) begin
            r_win <= n_win;
        end
    end

    assign o_item_push = r_f1_valid && r_f1_emit;
    assign o_item.clr  = r_f1_clr;
    assign o_item.last = r_f1_last;
    assign o_item.win  = n_win;

endmodule

/* rtl/core/sem_back.sv */
// back part: sobel gradients, saturated l1 magnitude and frame sum
// depends on sem_pkg
module sem_back
    import sem_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_empty,
    input  t_win_item           i_item,
    output logic                o_q_pop,
    input  logic [OQ_CNT_W-1:0] i_oq_count,
    output logic                o_res_push,
    output t_result             o_res
);

    localparam int SW  = PIX_W + 2;
    localparam int MW  = SW + 1;
    localparam int SXW = SUM_W + 1;

    logic [SW-1:0]        gx_pos;
    logic [SW-1:0]        gx_neg;
    logic [SW-1:0]        gy_pos;
    logic [SW-1:0]        gy_neg;
    logic signed [SW:0]   gx;
    logic signed [SW:0]   gy;

    logic                 r_b1_valid;
    logic signed [SW:0]   r_b1_gx;
    logic signed [SW:0]   r_b1_gy;
    logic                 r_b1_last;
    logic                 r_b1_clr;

    logic [SW-1:0]        ax;
    logic [SW-1:0]        ay;
    logic [MW-1:0]        mag;
    logic [PIX_W-1:0]     edge_sat;

    logic                 r_b2_valid;
    logic [PIX_W-1:0]     r_b2_edge;
    logic                 r_b2_last;
    logic                 r_b2_clr;

    logic [SUM_W-1:0]     r_sum;
    logic [SUM_W-1:0]     sum_base;
    logic [SXW-1:0]       sum_wide;
    logic [SUM_W-1:0]     sum_sat;
    logic [OQ_OCC_W-1:0]  occ;

    // pop only with room for everything still in the two stages
    assign occ = OQ_OCC_W'(i_oq_count) + OQ_OCC_W'(r_b1_valid) + OQ_OCC_W'(r_b2_valid);
    assign o_q_pop = !i_q_empty && (occ < OQ_OCC_W'(OQ_DEPTH));

    assign gx_pos = SW'(i_item.win[2]) + {1'b0, i_item.win[5], 1'b0} + SW'(i_item.win[8]);
    assign gx_neg = SW'(i_item.win[0]) + {1'b0, i_item.win[3], 1'b0} + SW'(i_item.win[6]);
    assign gy_pos = SW'(i_item.win[6]) + {1'b0, i_item.win[7], 1'b0} + SW'(i_item.win[8]);
    assign gy_neg = SW'(i_item.win[0]) + {1'b0, i_item.win[1], 1'b0} + SW'(i_item.win[2]);
    assign gx = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
    assign gy = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});

    assign ax = r_b1_gx[SW] ? SW'(-r_b1_gx) : SW'(r_b1_gx);
    assign ay = r_b1_gy[SW] ? SW'(-r_b1_gy) : SW'(r_b1_gy);
    assign mag = MW'(ax) + MW'(ay);
    assign edge_sat = (mag > MW'(EDGE_MAX)) ? EDGE_MAX : mag[PIX_W-1:0];

    assign sum_base = r_b2_clr ? '0 : r_sum;
    assign sum_wide = SXW'(sum_base) + SXW'(r_b2_edge);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_sum      <= '0;
        end else begin
            r_b1_valid <= o_q_pop;
            r_b2_valid <= r_b1_valid;
            if (r_b2_valid) begin
                r_sum <= sum_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_b1_gx   <= gx;
            r_b1_gy   <= gy;
            r_b1_last <= i_item.last;
            r_b1_clr  <= i_item.clr;
        end
        if (r_b1_valid) begin
            r_b2_edge <= edge_sat;
            r_b2_last <= r_b1_last;
            r_b2_clr  <= r_b1_clr;
        end
    end

    assign o_res_push          = r_b2_valid;
    assign o_res.edge_value    = r_b2_edge;
    assign o_res.last_of_frame = r_b2_last;
    assign o_res.frame_sum     = sum_sat;

endmodule

/* rtl/core/sobel_edge_magnitude_top.sv */
// top level of the sobel 3x3 edge magnitude block: config registers and queues
// depends on sem_pkg, sem_fifo, sem_front, sem_back
//
// channel   direction  handshake        payload
// pixel     in         push / full      i_pixel_in[7:0]
// result    out        empty / pop      o_edge_value[7:0], o_last_of_frame, o_frame_sum[29:0]
// config    in         i_cfg_we         i_cfg_index[0], i_cfg_data[11:0]
//
// one pixel per cycle while full is low; from a taken pixel, a result reaches the result ports through:
// window stage, front/back queue, gradient stage, then magnitude and sum into the result queue
// each line buffer takes one read and one write per cycle, which holds the rate at one pixel
// full rises when the front/back queue, counting the window stage, has no free slot; the back
// stops popping while the result queue and its two stages hold four results
// reset is synchronous and clears counters, window, sum and queues; line buffers are not cleared
module sobel_edge_magnitude_top
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [PIX_W-1:0]     i_pixel_in,
    output logic                 empty,
    input  logic                 pop,
    output logic [PIX_W-1:0]     o_edge_value,
    output logic                 o_last_of_frame,
    output logic [SUM_W-1:0]     o_frame_sum,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]    r_image_width;
    logic [CFG_W-1:0]    r_image_height;

    logic                front_push;
    t_win_item           front_item;
    logic [$bits(t_win_item)-1:0] mq_rdata;
    t_win_item           mq_item;
    logic                mq_empty;
    logic [MQ_CNT_W-1:0] mq_count;
    logic                mq_pop;

    logic                res_push;
    t_result             res_item;
    logic [$bits(t_result)-1:0] oq_rdata;
    t_result             oq_item;
    logic [OQ_CNT_W-1:0] oq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= CFG_SIZE_RESET;
            r_image_height <= CFG_SIZE_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
            endcase
        end
    end

    sem_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_pixel        (i_pixel_in),
        .i_image_width  (r_image_width),
        .i_image_height (r_image_height),
        .i_q_count      (mq_count),
        .o_full         (full),
        .o_item_push    (front_push),
        .o_item         (front_item)
    );

    sem_fifo #(
        .WIDTH ($bits(t_win_item)),
        .DEPTH (MQ_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_item),
        .i_pop   (mq_pop),
        .o_data  (mq_rdata),
        .o_empty (mq_empty),
        .o_count (mq_count)
    );

    assign mq_item = t_win_item'(mq_rdata);

    sem_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (mq_empty),
        .i_item     (mq_item),
        .o_q_pop    (mq_pop),
        .i_oq_count (oq_count),
        .o_res_push (res_push),
        .o_res      (res_item)
    );

    sem_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OQ_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_item),
        .i_pop   (pop),
        .o_data  (oq_rdata),
        .o_empty (empty),
        .o_count (oq_count)
    );

    assign oq_item         = t_result'(oq_rdata);
    assign o_edge_value    = oq_item.edge_value;
    assign o_last_of_frame = oq_item.last_of_frame;
    assign o_frame_sum     = oq_item.frame_sum;

endmodule

/* rtl/core/sem_checker.sv */
// port-level checks of the sobel edge magnitude top, attached by bind
// depends on sem_pkg and assert_macros.svh
`include "assert_macros.svh"

module sem_checker
    import sem_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 empty,
    input  logic                 pop,
    input  logic [PIX_W-1:0]     o_edge_value,
    input  logic                 o_last_of_frame,
    input  logic [SUM_W-1:0]     o_frame_sum
);

    // set while the next result opens a frame
    logic r_after_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_after_last <= 1'b1;
        end else if (pop && !empty) begin
            r_after_last <= o_last_of_frame;
        end
    end

    `SEM_ASSERT_ALWAYS(a_empty_after_reset, !i_rst_n |=> empty,
        "result queue not empty after reset")

    `SEM_ASSERT(a_result_held, (!empty && !pop) |=> !empty,
        "waiting result vanished without pop")

    `SEM_ASSERT(a_sum_covers_edge, !empty |-> (o_frame_sum >= SUM_W'(o_edge_value)),
        "frame sum below edge value")

    `SEM_ASSERT(a_frame_restart,
        (r_after_last && !empty) |-> (o_frame_sum == SUM_W'(o_edge_value)),
        "first result of frame carries stale sum")

endmodule

bind sobel_edge_magnitude_top sem_checker u_sem_checker (.*);
